@@ src/iphc_pkg.sv @@
// ----------------------------------------------------------------------------
// iphc_pkg
// Shared result type, byte positions and checksum helper for the IPv4 header
// parse and checksum unit.
// ----------------------------------------------------------------------------
package iphc_pkg;

	localparam int unsigned HEADER_BYTES = 20;
	localparam int unsigned IDX_W        = 5;
	localparam int unsigned SUM_W        = 20;
	localparam int unsigned OUT_W        = 144;

	localparam logic [31:0] OWN_IP_RESET = 32'hC0A8_1832;

	// header byte positions
	localparam logic [IDX_W-1:0] IDX_VER       = 5'd0;
	localparam logic [IDX_W-1:0] IDX_DSCP      = 5'd1;
	localparam logic [IDX_W-1:0] IDX_LEN_HI    = 5'd2;
	localparam logic [IDX_W-1:0] IDX_LEN_LO    = 5'd3;
	localparam logic [IDX_W-1:0] IDX_ID_HI     = 5'd4;
	localparam logic [IDX_W-1:0] IDX_ID_LO     = 5'd5;
	localparam logic [IDX_W-1:0] IDX_FLAGS     = 5'd6;
	localparam logic [IDX_W-1:0] IDX_TTL       = 5'd8;
	localparam logic [IDX_W-1:0] IDX_PROTO     = 5'd9;
	localparam logic [IDX_W-1:0] IDX_CSUM_LO   = 5'd11;
	localparam logic [IDX_W-1:0] IDX_SRC_0     = 5'd12;
	localparam logic [IDX_W-1:0] IDX_SRC_1     = 5'd13;
	localparam logic [IDX_W-1:0] IDX_SRC_2     = 5'd14;
	localparam logic [IDX_W-1:0] IDX_SRC_3     = 5'd15;
	localparam logic [IDX_W-1:0] IDX_DST_0     = 5'd16;
	localparam logic [IDX_W-1:0] IDX_DST_1     = 5'd17;
	localparam logic [IDX_W-1:0] IDX_DST_2     = 5'd18;
	localparam logic [IDX_W-1:0] IDX_LAST      = 5'd19;
	localparam logic [IDX_W-1:0] IDX_DONE      = 5'd20;

	typedef struct packed {
		logic [3:0]  version;
		logic [5:0]  dscp;
		logic [15:0] total_length;
		logic [15:0] identification;
		logic [2:0]  flags;
		logic [7:0]  ttl;
		logic [7:0]  protocol;
		logic [15:0] computed_checksum;
		logic        checksum_ok;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic        dest_is_mine;
	} iphc_result_t;

	// end-around carry fold of a 20-bit sum down to 16 bits
	function automatic logic [15:0] fold16(input logic [SUM_W-1:0] s);
		logic [16:0] s1;
		logic [16:0] s2;
		s1 = {1'b0, s[15:0]} + {13'd0, s[19:16]};
		s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
		return s2[15:0];
	endfunction

endpackage

@@ src/iphc_parse.sv @@
// ----------------------------------------------------------------------------
// iphc_parse
// Byte counter, running word sums and field capture for one IPv4 header;
// presents the finished result alongside the last header byte.
// ----------------------------------------------------------------------------
module iphc_parse import iphc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    hdr_byte,
	input  logic          first,
	input  logic [31:0]   own_ip,
	output logic          res_valid,
	output iphc_result_t  res
);

	logic [IDX_W-1:0] byte_idx_q;
	logic [SUM_W-1:0] word_sum_q;
	logic [SUM_W-1:0] excl_sum_q;
	logic [7:0]       pend_q;
	logic [3:0]       version_q;
	logic [5:0]       dscp_q;
	logic [15:0]      length_q;
	logic [15:0]      ident_q;
	logic [2:0]       flags_q;
	logic [7:0]       ttl_q;
	logic [7:0]       proto_q;
	logic [31:0]      src_q;
	logic [23:0]      dst_q;

	logic [IDX_W-1:0] idx;
	logic             active;
	logic [15:0]      word;
	logic [SUM_W-1:0] sum_base;
	logic [SUM_W-1:0] excl_base;
	logic [SUM_W-1:0] sum_nxt;
	logic [SUM_W-1:0] excl_nxt;
	logic [31:0]      dst_full;
	logic [15:0]      all_fold;

	always_comb begin
		idx       = first ? IDX_VER : byte_idx_q;
		sum_base  = first ? '0 : word_sum_q;
		excl_base = first ? '0 : excl_sum_q;
		active    = (idx < IDX_DONE);
		word      = {pend_q, hdr_byte};
		sum_nxt   = sum_base + (idx[0] ? {4'd0, word} : '0);
		// the checksum word itself is left out of the recomputed sum
		excl_nxt  = excl_base + ((idx[0] && idx != IDX_CSUM_LO) ? {4'd0, word} : '0);
		dst_full  = {dst_q, hdr_byte};
		all_fold  = fold16(sum_nxt);

		res_valid             = active && (idx == IDX_LAST);
		res.version           = version_q;
		res.dscp              = dscp_q;
		res.total_length      = length_q;
		res.identification    = ident_q;
		res.flags             = flags_q;
		res.ttl               = ttl_q;
		res.protocol          = proto_q;
		res.computed_checksum = ~fold16(excl_nxt);
		res.checksum_ok       = (all_fold == 16'hFFFF);
		res.src_addr          = src_q;
		res.dst_addr          = dst_full;
		res.dest_is_mine      = (dst_full == own_ip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			word_sum_q <= '0;
			excl_sum_q <= '0;
		end else if (step && active) begin
			byte_idx_q <= idx + 1'b1;
			word_sum_q <= sum_nxt;
			excl_sum_q <= excl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step && active) begin
			if (!idx[0]) begin
				pend_q <= hdr_byte;
			end
			unique case (idx)
				IDX_VER:    version_q        <= hdr_byte[7:4];
				IDX_DSCP:   dscp_q           <= hdr_byte[7:2];
				IDX_LEN_HI: length_q[15:8]   <= hdr_byte;
				IDX_LEN_LO: length_q[7:0]    <= hdr_byte;
				IDX_ID_HI:  ident_q[15:8]    <= hdr_byte;
				IDX_ID_LO:  ident_q[7:0]     <= hdr_byte;
				IDX_FLAGS:  flags_q          <= hdr_byte[7:5];
				IDX_TTL:    ttl_q            <= hdr_byte;
				IDX_PROTO:  proto_q          <= hdr_byte;
				IDX_SRC_0:  src_q[31:24]     <= hdr_byte;
				IDX_SRC_1:  src_q[23:16]     <= hdr_byte;
				IDX_SRC_2:  src_q[15:8]      <= hdr_byte;
				IDX_SRC_3:  src_q[7:0]       <= hdr_byte;
				IDX_DST_0:  dst_q[23:16]     <= hdr_byte;
				IDX_DST_1:  dst_q[15:8]      <= hdr_byte;
				IDX_DST_2:  dst_q[7:0]       <= hdr_byte;
				default: begin
				end
			endcase
		end
	end

endmodule

@@ src/ipv4_header_parse_checksum_unit.sv @@
// ----------------------------------------------------------------------------
// ipv4_header_parse_checksum_unit
// Parses a basic 20-byte IPv4 header one byte per item, recomputes and
// verifies the header checksum and checks the destination address.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      per item
//  s_axis    in   tdata: header_byte, tuser: first_byte        one header byte
//  m_axis    out  tdata: parsed fields, checksum, flags        one per header
//  cfg       in   cfg_wdata: own_ip_address                    register write
//
//  one byte per clock while m_axis is not stalled; a byte waits in the
//  input register, and the result is loaded into the output register as
//  the 20th byte leaves it. both registers advance together, so a stalled
//  result holds the input side. reset clears the byte count and sums and
//  loads the own address with 192.168.24.50.
// ----------------------------------------------------------------------------
module ipv4_header_parse_checksum_unit import iphc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // header_byte
	input  logic              s_axis_tuser,   // first_byte
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// version, dscp, total_length, identification, flags, ttl, protocol,
	// computed_checksum, checksum_ok, src_addr, dst_addr,
	// dest_is_mine, zero pad
	output logic [OUT_W-1:0]  m_axis_tdata,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         first_s1;
	logic         out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic [31:0]  own_ip_q;

	logic         advance;
	logic         step;
	logic         res_valid;
	iphc_result_t res;

	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= OWN_IP_RESET;
		end else if (cfg_we) begin
			own_ip_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= step && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
		end
		if (step && res_valid) begin
			out_data_q <= {1'b0,
				res.dest_is_mine, res.dst_addr, res.src_addr,
				res.checksum_ok, res.computed_checksum, res.protocol, res.ttl,
				res.flags, res.identification, res.total_length, res.dscp,
				res.version};
		end
	end

	iphc_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.hdr_byte  (byte_s1),
		.first     (first_s1),
		.own_ip    (own_ip_q),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

@@ dv/ipv4_header_parse_checksum_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_parse_checksum_unit_tb
// Streams IPv4 header bytes into the parser and checks every parsed header
// against a cycle-free model of the byte counter, field capture and ones'
// complement checksum, under several idle and backpressure patterns and
// several own-address settings.
// ----------------------------------------------------------------------------
module ipv4_header_parse_checksum_unit_tb;
	import iphc_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int SHOWN_MISMATCHES = 10;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = 8'h00;    // header_byte
	logic             s_axis_tuser = 1'b0;     // first_byte
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// version, dscp, total_length, identification, flags, ttl, protocol,
	// computed_checksum, checksum_ok, src_addr, dst_addr,
	// dest_is_mine, zero pad
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_we = 1'b0;
	logic [31:0]      cfg_wdata = 32'h0;

	ipv4_header_parse_checksum_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// header parser model state
	logic [IDX_W-1:0] byte_pos;
	logic [SUM_W-1:0] run_sum;
	logic [7:0]       high_byte;
	logic [15:0]      csum_word;
	iphc_result_t     hold;
	logic [31:0]      own_ip_model;

	iphc_result_t     expected_headers[$];
	int               mismatches = 0;

	int               idle_pct = 0;
	int               stall_pct = 0;
	int               hold_off_len = 0;
	int               hold_left = 0;

	logic [7:0]       hdr[HEADER_BYTES];

	function automatic logic [15:0] ones_fold(input logic [31:0] s);
		s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
		s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
		return s[15:0];
	endfunction

	task automatic parse_header_byte(input logic [7:0] b, input logic first);
		logic [IDX_W-1:0] pos;
		logic [15:0]      word;
		if (first) begin
			byte_pos = '0;
			run_sum = '0;
		end
		// past the 20th byte everything is dropped until the next mark
		if (byte_pos < IDX_DONE) begin
			pos = byte_pos;
			if (!pos[0]) begin
				high_byte = b;
			end else begin
				word = {high_byte, b};
				run_sum = run_sum + {{(SUM_W-16){1'b0}}, word};
				if (pos == IDX_CSUM_LO)
					csum_word = word;
			end
			case (pos)
				IDX_VER: hold.version = b[7:4];
				IDX_DSCP: hold.dscp = b[7:2];
				IDX_LEN_HI, IDX_LEN_LO: hold.total_length = {hold.total_length[7:0], b};
				IDX_ID_HI, IDX_ID_LO: hold.identification = {hold.identification[7:0], b};
				IDX_FLAGS: hold.flags = b[7:5];
				IDX_TTL: hold.ttl = b;
				IDX_PROTO: hold.protocol = b;
				IDX_SRC_0, IDX_SRC_1, IDX_SRC_2, IDX_SRC_3: begin
					hold.src_addr = {hold.src_addr[23:0], b};
				end
				IDX_DST_0, IDX_DST_1, IDX_DST_2, IDX_LAST: begin
					hold.dst_addr = {hold.dst_addr[23:0], b};
				end
				default: ;
			endcase
			byte_pos = pos + 1'b1;
			if (byte_pos == IDX_DONE) begin
				hold.computed_checksum =
					~ones_fold({12'h0, run_sum} - {16'h0, csum_word});
				hold.checksum_ok = (~ones_fold({12'h0, run_sum}) == 16'h0);
				hold.dest_is_mine = (hold.dst_addr == own_ip_model);
				expected_headers.push_back(hold);
			end
		end
	endtask

	function automatic iphc_result_t unpack_header(input logic [OUT_W-1:0] d);
		iphc_result_t r;
		r.version           = d[3:0];
		r.dscp              = d[9:4];
		r.total_length      = d[25:10];
		r.identification    = d[41:26];
		r.flags             = d[44:42];
		r.ttl               = d[52:45];
		r.protocol          = d[60:53];
		r.computed_checksum = d[76:61];
		r.checksum_ok       = d[77];
		r.src_addr          = d[109:78];
		r.dst_addr          = d[141:110];
		r.dest_is_mine      = d[142];
		return r;
	endfunction

	task automatic note_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= SHOWN_MISMATCHES)
				$display("mismatch in %s: expected %h, got %h", field, want, got);
		end
	endtask

	task automatic check_header(input logic [OUT_W-1:0] d);
		iphc_result_t got;
		iphc_result_t want;
		got = unpack_header(d);
		if (expected_headers.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOWN_MISMATCHES)
				$display("unexpected header result %h", d);
		end else begin
			want = expected_headers.pop_front();
			note_field("version", 32'(want.version), 32'(got.version));
			note_field("dscp", 32'(want.dscp), 32'(got.dscp));
			note_field("total_length", 32'(want.total_length),
				32'(got.total_length));
			note_field("identification", 32'(want.identification),
				32'(got.identification));
			note_field("flags", 32'(want.flags), 32'(got.flags));
			note_field("ttl", 32'(want.ttl), 32'(got.ttl));
			note_field("protocol", 32'(want.protocol), 32'(got.protocol));
			note_field("computed_checksum", 32'(want.computed_checksum),
				32'(got.computed_checksum));
			note_field("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
			note_field("src_addr", want.src_addr, got.src_addr);
			note_field("dst_addr", want.dst_addr, got.dst_addr);
			note_field("dest_is_mine", 32'(want.dest_is_mine),
				32'(got.dest_is_mine));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_header(m_axis_tdata);
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left == 0 && hold_off_len != 0) begin
			hold_left = hold_off_len;
			hold_off_len = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// called right after a rising edge; valid stays high for back-to-back items
	task automatic send_byte(input logic [7:0] b, input logic first);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= first;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		parse_header_byte(b, first);
	endtask

	task automatic send_header(input int n, input logic mark);
		int i;
		for (i = 0; i < n; i++)
			send_byte(hdr[i], mark && (i == 0));
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_headers.size() != 0)
			@(posedge clk);
		// ignored bytes may still sit in the input register
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_own_ip(input logic [31:0] addr);
		cfg_we <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_we <= 1'b0;
		own_ip_model = addr;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic build_header(input logic good_csum, input logic to_me);
		logic [31:0] sum;
		logic [15:0] csum;
		int i;
		for (i = 0; i < HEADER_BYTES; i++)
			hdr[i] = pick_byte();
		if ($urandom_range(3) != 0)
			hdr[0] = 8'h45;
		if (to_me)
			{hdr[16], hdr[17], hdr[18], hdr[19]} = own_ip_model;
		if (good_csum) begin
			hdr[10] = 8'h00;
			hdr[11] = 8'h00;
			sum = 32'h0;
			for (i = 0; i < HEADER_BYTES; i += 2)
				sum = sum + {16'h0, hdr[i], hdr[i+1]};
			csum = ~ones_fold(sum);
			{hdr[10], hdr[11]} = csum;
		end
	endtask

	task automatic test_zero_header_after_reset();
		int i;
		for (i = 0; i < HEADER_BYTES; i++)
			hdr[i] = 8'h00;
		// no mark: the count starts at byte 0 out of reset
		send_header(HEADER_BYTES, 1'b0);
	endtask

	task automatic test_ignored_tail();
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
	endtask

	task automatic test_restart_mid_header();
		int i;
		for (i = 0; i < HEADER_BYTES; i++)
			hdr[i] = 8'hFF;
		send_header(3, 1'b1);
		send_header(HEADER_BYTES, 1'b1);
	endtask

	task automatic test_valid_header_to_me();
		build_header(1'b1, 1'b1);
		send_header(HEADER_BYTES, 1'b1);
	endtask

	task automatic test_random_headers(input int send_idle, input int recv_stall,
			input int n_headers);
		int h;
		int n;
		idle_pct = send_idle;
		stall_pct = recv_stall;
		for (h = 0; h < n_headers; h++) begin
			build_header($urandom_range(3) != 0, $urandom_range(2) == 0);
			case ($urandom_range(9))
				0: begin
					// broken header, then restarted by the next mark
					send_header($urandom_range(1, HEADER_BYTES - 1), 1'b1);
					send_header(HEADER_BYTES, 1'b1);
				end
				1: begin
					send_header(HEADER_BYTES, 1'b1);
					n = $urandom_range(1, 3);
					repeat (n) send_byte(8'($urandom), 1'b0);
				end
				2: send_header(HEADER_BYTES, 1'b0);
				default: send_header(HEADER_BYTES, 1'b1);
			endcase
		end
	endtask

	task automatic test_backpressure_fill();
		int h;
		idle_pct = 0;
		stall_pct = 0;
		hold_off_len = 300;
		for (h = 0; h < 8; h++) begin
			build_header(1'b1, h[0]);
			send_header(HEADER_BYTES, 1'b1);
		end
	endtask

	initial begin
		byte_pos = '0;
		run_sum = '0;
		high_byte = '0;
		csum_word = '0;
		hold = '0;
		own_ip_model = OWN_IP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_header_after_reset();
		test_ignored_tail();
		test_restart_mid_header();
		test_valid_header_to_me();
		wait_idle();

		write_own_ip(32'h0000_0000);
		test_random_headers(0, 0, 3);
		wait_idle();
		write_own_ip(32'hFFFF_FFFF);
		test_random_headers(59, 0, 3);
		wait_idle();
		write_own_ip($urandom);
		test_random_headers(0, 59, 3);
		wait_idle();
		write_own_ip(OWN_IP_RESET);
		test_random_headers(26, 26, 3);
		wait_idle();
		write_own_ip($urandom);
		test_backpressure_fill();
		wait_idle();
		test_random_headers(26, 26, 2);
		wait_idle();

		if (mismatches == 0 && expected_headers.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ sim.f @@
src/iphc_pkg.sv
src/iphc_parse.sv
src/ipv4_header_parse_checksum_unit.sv
dv/ipv4_header_parse_checksum_unit_tb.sv
